[hdl/pgwalk_pkg.sv]
`default_nettype none

package pgwalk_pkg;

   localparam int TABLE_PAGES       = 16;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int PG_W              = $clog2(TABLE_PAGES);
   localparam int ADDR_W            = PG_W + IDX_W;
   localparam int DEPTH             = TABLE_PAGES * ENTRIES_PER_TABLE;
   localparam int NFP_W             = ($clog2(TABLE_PAGES + 1) > 4) ?
                                      $clog2(TABLE_PAGES + 1) : 4;
   localparam int FRAME_W           = 40;

   // entry bit positions
   localparam int BIT_P    = 0;
   localparam int BIT_W    = 1;
   localparam int BIT_U    = 2;
   localparam int BIT_HUGE = 7;
   localparam int BIT_NX   = 63;

   typedef enum logic [1:0] {
      CMD_TRANSLATE = 2'd0,
      CMD_MAP_4K    = 2'd1,
      CMD_MAP_2M    = 2'd2,
      CMD_UNMAP     = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_OUTSIDE   = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      REG_POOL_BASE_FRAME = 1'b0,
      REG_RESERVED_ROOTS  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      S_CLEAR_ALL,
      S_IDLE,
      S_READ,
      S_EVAL,
      S_CLR_PAGE,
      S_LINK,
      S_LEAF,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  root_page;
      logic [47:0] virt_addr;
      logic [51:0] phys_addr;
      logic        writable;
      logic        user_access;
      logic        no_execute;
   } req_type;

   typedef struct packed {
      logic [51:0] phys_result;
      logic        mapped;
      logic [1:0]  status;
   } rsp_type;

   function automatic logic [IDX_W-1:0] level_index(input logic [47:0] va,
                                                     input logic [1:0]  lvl);
      logic [IDX_W-1:0] idx;
      case (lvl)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         2'd2:    idx = va[29:21];
         default: idx = va[20:12];
      endcase
      return idx;
   endfunction

endpackage

`default_nettype wire

[hdl/four_level_page_table_walker_core.sv]
// Four-level page-table walker with a private pool of table pages.
// Input channel req_*: one command per transfer (translate, map 4K, map 2MB,
// unmap). Result channel rsp_*: exactly one result per command, in order.
// Configuration through the csr_* APB port: pool_base_frame at 0x0,
// reserved_roots at 0x8 (writing it also reloads the page allocator).
// All table entries sit in one single-port RAM of 8192 x 64 bits with a
// registered read; the walk is a read/evaluate loop over it.
// Each table level takes a read state and an evaluate state, and a finish
// state ends the command; a leaf or pointer write adds a state. Each new
// table page is zeroed by a sweep over its 512 entries before it is linked.
// One command is in flight at a time; the next one is taken once the
// previous result has been moved to the output register.
// After reset the whole RAM is cleared, one entry per cycle; req_ready
// stays low during the clear (CSR writes are still taken).
// A stalled receiver (rsp_ready low) holds the result in the output
// register; a following command may run but waits at completion.
`default_nettype none

module four_level_page_table_walker_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire pgwalk_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output pgwalk_pkg::rsp_type      rsp_data,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [3:0]          csr_paddr,
   input  wire logic [63:0]         csr_pwdata,
   output logic [63:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int PG_W    = pgwalk_pkg::PG_W;
   localparam int ADDR_W  = pgwalk_pkg::ADDR_W;
   localparam int NFP_W   = pgwalk_pkg::NFP_W;
   localparam int FRAME_W = pgwalk_pkg::FRAME_W;
   localparam int IDX_W   = pgwalk_pkg::IDX_W;

   logic [63:0] mem [pgwalk_pkg::DEPTH];

   pgwalk_pkg::state_type state_ff, state_in;
   pgwalk_pkg::req_type   req_ff, req_in;
   pgwalk_pkg::rsp_type   res_ff, res_in;
   pgwalk_pkg::rsp_type   rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            lvl_ff, lvl_in;
   logic [PG_W-1:0]       pg_ff, pg_in;
   logic [PG_W-1:0]       new_pg_ff, new_pg_in;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic [NFP_W-1:0]      nfp_ff, nfp_in;
   logic [FRAME_W-1:0]    base_ff, base_in;
   logic [3:0]            rroots_ff, rroots_in;
   logic [63:0]           mem_q_ff;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_addr;
   logic [63:0]           mem_wdata;

   logic                  csr_wr;
   logic                  req_xfer;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign req_ready  = (state_ff == pgwalk_pkg::S_IDLE);
   assign req_xfer   = req_valid & req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      if (csr_paddr[3] == pgwalk_pkg::REG_RESERVED_ROOTS) begin
         csr_prdata = {60'd0, rroots_ff};
      end else begin
         csr_prdata = {{(64 - FRAME_W){1'b0}}, base_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgwalk_pkg::S_CLEAR_ALL;
         rsp_valid_ff <= 1'b0;
         sweep_ff     <= '0;
         nfp_ff       <= NFP_W'(1);
         base_ff      <= '0;
         rroots_ff    <= 4'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sweep_ff     <= sweep_in;
         nfp_ff       <= nfp_in;
         base_ff      <= base_in;
         rroots_ff    <= rroots_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
      lvl_ff    <= lvl_in;
      pg_ff     <= pg_in;
      new_pg_ff <= new_pg_in;
   end

   always_comb begin
      logic [63:0]        e;
      logic [FRAME_W-1:0] off;
      logic               in_pool;
      logic [1:0]         leaf_lvl;
      logic [1:0]         lvl_next;
      logic [IDX_W-1:0]   idx;
      logic [FRAME_W-1:0] frame;
      logic [63:0]        leaf;

      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      lvl_in       = lvl_ff;
      pg_in        = pg_ff;
      new_pg_in    = new_pg_ff;
      sweep_in     = sweep_ff;
      nfp_in       = nfp_ff;
      base_in      = base_ff;
      rroots_in    = rroots_ff;
      mem_we       = 1'b0;
      mem_addr     = {pg_ff, pgwalk_pkg::level_index(req_ff.virt_addr, lvl_ff)};
      mem_wdata    = '0;

      e        = mem_q_ff;
      off      = e[51:12] - base_ff;
      in_pool  = (off < FRAME_W'(pgwalk_pkg::TABLE_PAGES));
      leaf_lvl = (req_ff.command == pgwalk_pkg::CMD_MAP_2M) ? 2'd2 : 2'd3;
      lvl_next = lvl_ff + 2'd1;
      idx      = pgwalk_pkg::level_index(req_ff.virt_addr, lvl_ff);
      frame    = base_ff + FRAME_W'(new_pg_ff);
      leaf     = '0;
      leaf[pgwalk_pkg::BIT_P] = 1'b1;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pgwalk_pkg::S_CLEAR_ALL: begin
            mem_we    = 1'b1;
            mem_addr  = sweep_ff;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(pgwalk_pkg::DEPTH - 1)) begin
               state_in = pgwalk_pkg::S_IDLE;
            end
         end
         pgwalk_pkg::S_IDLE: begin
            if (req_xfer) begin
               req_in = req_data;
               lvl_in = 2'd0;
               pg_in  = PG_W'(req_data.root_page);
               res_in = '{phys_result: '0, mapped: 1'b0, status: pgwalk_pkg::ST_OK};
               if (NFP_W'(req_data.root_page) >= NFP_W'(pgwalk_pkg::TABLE_PAGES)) begin
                  res_in.status = pgwalk_pkg::ST_OUTSIDE;
                  state_in      = pgwalk_pkg::S_FIN;
               end else begin
                  state_in = pgwalk_pkg::S_READ;
               end
            end
         end
         pgwalk_pkg::S_READ: begin
            state_in = pgwalk_pkg::S_EVAL;
         end
         pgwalk_pkg::S_EVAL: begin
            if (req_ff.command == pgwalk_pkg::CMD_TRANSLATE) begin
               if (!e[pgwalk_pkg::BIT_P]) begin
                  state_in = pgwalk_pkg::S_FIN;
               end else if (lvl_ff == 2'd3) begin
                  res_in.phys_result = {e[51:12], req_ff.virt_addr[11:0]};
                  res_in.mapped      = 1'b1;
                  state_in           = pgwalk_pkg::S_FIN;
               end else if (e[pgwalk_pkg::BIT_HUGE] && lvl_ff == 2'd1) begin
                  res_in.phys_result = {e[51:30], req_ff.virt_addr[29:0]};
                  res_in.mapped      = 1'b1;
                  state_in           = pgwalk_pkg::S_FIN;
               end else if (e[pgwalk_pkg::BIT_HUGE] && lvl_ff == 2'd2) begin
                  res_in.phys_result = {e[51:21], req_ff.virt_addr[20:0]};
                  res_in.mapped      = 1'b1;
                  state_in           = pgwalk_pkg::S_FIN;
               end else if (!in_pool) begin
                  res_in.status = pgwalk_pkg::ST_OUTSIDE;
                  state_in      = pgwalk_pkg::S_FIN;
               end else begin
                  pg_in    = off[PG_W-1:0];
                  lvl_in   = lvl_next;
                  state_in = pgwalk_pkg::S_READ;
               end
            end else if (e[pgwalk_pkg::BIT_P]) begin
               // present entries, huge or not, are followed as table pointers
               if (!in_pool) begin
                  res_in.status = pgwalk_pkg::ST_OUTSIDE;
                  state_in      = pgwalk_pkg::S_FIN;
               end else begin
                  pg_in    = off[PG_W-1:0];
                  lvl_in   = lvl_next;
                  state_in = (lvl_next == leaf_lvl) ? pgwalk_pkg::S_LEAF
                                                    : pgwalk_pkg::S_READ;
               end
            end else if (req_ff.command == pgwalk_pkg::CMD_UNMAP) begin
               state_in = pgwalk_pkg::S_FIN;
            end else if (nfp_ff >= NFP_W'(pgwalk_pkg::TABLE_PAGES)) begin
               res_in.status = pgwalk_pkg::ST_EXHAUSTED;
               state_in      = pgwalk_pkg::S_FIN;
            end else begin
               new_pg_in = nfp_ff[PG_W-1:0];
               nfp_in    = nfp_ff + NFP_W'(1);
               sweep_in  = '0;
               state_in  = pgwalk_pkg::S_CLR_PAGE;
            end
         end
         pgwalk_pkg::S_CLR_PAGE: begin
            // zero the new table before linking; it may be the parent itself
            mem_we   = 1'b1;
            mem_addr = {new_pg_ff, sweep_ff[IDX_W-1:0]};
            sweep_in = sweep_ff + ADDR_W'(1);
            if (sweep_ff[IDX_W-1:0] == {IDX_W{1'b1}}) begin
               state_in = pgwalk_pkg::S_LINK;
            end
         end
         pgwalk_pkg::S_LINK: begin
            mem_we    = 1'b1;
            mem_addr  = {pg_ff, idx};
            mem_wdata = {12'd0, frame, 12'd0};
            mem_wdata[pgwalk_pkg::BIT_P] = 1'b1;
            mem_wdata[pgwalk_pkg::BIT_W] = 1'b1;
            mem_wdata[pgwalk_pkg::BIT_U] = 1'b1;
            pg_in     = new_pg_ff;
            lvl_in    = lvl_next;
            state_in  = (lvl_next == leaf_lvl) ? pgwalk_pkg::S_LEAF
                                               : pgwalk_pkg::S_READ;
         end
         pgwalk_pkg::S_LEAF: begin
            mem_we   = 1'b1;
            mem_addr = {pg_ff, idx};
            if (req_ff.command == pgwalk_pkg::CMD_MAP_2M) begin
               leaf[51:21] = req_ff.phys_addr[51:21];
               leaf[pgwalk_pkg::BIT_HUGE] = 1'b1;
            end else begin
               leaf[51:12] = req_ff.phys_addr[51:12];
            end
            leaf[pgwalk_pkg::BIT_W]  = req_ff.writable;
            leaf[pgwalk_pkg::BIT_U]  = req_ff.user_access;
            leaf[pgwalk_pkg::BIT_NX] = req_ff.no_execute;
            mem_wdata = (req_ff.command == pgwalk_pkg::CMD_UNMAP) ? 64'd0 : leaf;
            state_in  = pgwalk_pkg::S_FIN;
         end
         pgwalk_pkg::S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = pgwalk_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pgwalk_pkg::S_IDLE;
         end
      endcase

      if (csr_wr) begin
         if (csr_paddr[3] == pgwalk_pkg::REG_RESERVED_ROOTS) begin
            rroots_in = csr_pwdata[3:0];
            nfp_in    = NFP_W'(csr_pwdata[3:0]);
         end else begin
            base_in = csr_pwdata[FRAME_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire
